@@ hw/rtl/emarf_pkg.sv @@
// Shared constants, register codes and types of the oversampled EMA report filter.
package emarf_pkg;

    // Field widths of the ports.
    localparam int CHAN_W     = 2;
    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 9;
    localparam int HB_W       = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Filter level in unsigned 12.8 fixed point.
    localparam int FRAC_W  = 8;
    localparam int LEVEL_W = SAMPLE_W + FRAC_W;

    // Configuration limits and reset values.
    localparam logic [THR_W-1:0] THR_MIN   = 9'd1;
    localparam logic [THR_W-1:0] THR_MAX   = 9'd500;
    localparam logic [THR_W-1:0] THR_RESET = 9'd12;
    localparam logic [HB_W-1:0]  HB_RESET  = 16'd5000;

    // Default parameter values.
    localparam int CHANNELS_DEF   = 4;
    localparam int OVERSAMPLE_DEF = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT = 1'b1;

    // Decision of the update stage for one sample.
    typedef struct packed {
        logic                report;
        logic [SAMPLE_W-1:0] value;
    } t_result;

endpackage

@@ hw/rtl/emarf_state_ram.sv @@
// Per-channel state memory with registered read, valid bits and write forwarding.
module emarf_state_ram #(
    parameter int DEPTH  = emarf_pkg::CHANNELS_DEF,
    parameter int ADDR_W = 2,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DATA_W-1:0] r_rd_data;

    // Storage write and registered read. A write to the entry being read in the
    // same cycle is forwarded; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else if (r_vld[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    // Valid bits, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/emarf_update.sv @@
// Update datapath: accumulation, mean, EMA step, rounding and report decision.
module emarf_update #(
    parameter int OVERSAMPLE = emarf_pkg::OVERSAMPLE_DEF,
    parameter int SUM_W      = 16,
    parameter int CNT_W      = 4
) (
    input  logic [SUM_W-1:0]              i_sum,
    input  logic [CNT_W-1:0]              i_cnt,
    input  logic [emarf_pkg::LEVEL_W-1:0] i_level,
    input  logic                          i_primed,
    input  logic [emarf_pkg::SAMPLE_W-1:0] i_last_rep,
    input  logic [emarf_pkg::TIME_W-1:0]  i_last_time,
    input  logic [emarf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [emarf_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [emarf_pkg::THR_W-1:0]   i_threshold,
    input  logic [emarf_pkg::HB_W-1:0]    i_heartbeat,
    output logic [SUM_W-1:0]              o_sum,
    output logic [CNT_W-1:0]              o_cnt,
    output logic [emarf_pkg::LEVEL_W-1:0] o_level,
    output logic                          o_primed,
    output logic [emarf_pkg::SAMPLE_W-1:0] o_last_rep,
    output logic [emarf_pkg::TIME_W-1:0]  o_last_time,
    output emarf_pkg::t_result            o_result
);

    localparam int OS_W    = $clog2(OVERSAMPLE);
    localparam int SCALE_W = SUM_W + emarf_pkg::FRAC_W;
    localparam int LVL_W   = emarf_pkg::LEVEL_W;
    localparam int SMP_W   = emarf_pkg::SAMPLE_W;

    logic [SUM_W-1:0]   sum_acc;
    logic               group_done;
    logic [SCALE_W-1:0] scaled;
    logic [LVL_W-1:0]   mean;
    logic signed [LVL_W:0] diff;
    logic signed [LVL_W:0] step;
    logic [LVL_W-1:0]   level_new;
    logic [LVL_W:0]     rounded;
    logic [SMP_W:0]     value_wide;
    logic [SMP_W-1:0]   value;
    logic [SMP_W-1:0]   delta;
    logic [emarf_pkg::TIME_W-1:0] elapsed;
    logic               moved;
    logic               overdue;
    logic               report;

    // Accumulate and detect the sample that completes a group.
    assign sum_acc    = i_sum + SUM_W'(i_sample);
    assign group_done = (i_cnt == CNT_W'(OVERSAMPLE - 1));

    // Mean in 12.8: sum times 256 divided by the power-of-two group size.
    assign scaled = {sum_acc, emarf_pkg::FRAC_W'(0)};
    assign mean   = LVL_W'(scaled >> OS_W);

    // EMA with alpha of one quarter, arithmetic shift rounds toward minus infinity.
    assign diff      = $signed({1'b0, mean}) - $signed({1'b0, i_level});
    assign step      = diff >>> 2;
    assign level_new = i_primed ? LVL_W'($signed({1'b0, i_level}) + step) : mean;

    // Round half up to whole counts and saturate to the converter range.
    assign rounded    = {1'b0, level_new} + (LVL_W + 1)'(1 << (emarf_pkg::FRAC_W - 1));
    assign value_wide = rounded[LVL_W:emarf_pkg::FRAC_W];
    assign value      = value_wide[SMP_W] ? {SMP_W{1'b1}} : value_wide[SMP_W-1:0];

    // Report decision: threshold, heartbeat with wrapping time, or first mean.
    assign delta   = (value >= i_last_rep) ? (value - i_last_rep) : (i_last_rep - value);
    assign moved   = (delta >= SMP_W'(i_threshold));
    assign elapsed = i_now_ms - i_last_time;
    assign overdue = (elapsed >= emarf_pkg::TIME_W'(i_heartbeat));
    assign report  = group_done && (moved || overdue || !i_primed);

    // New state of the channel.
    always_comb begin
        o_sum       = group_done ? '0 : sum_acc;
        o_cnt       = group_done ? '0 : CNT_W'(i_cnt + 1'b1);
        o_level     = group_done ? level_new : i_level;
        o_primed    = i_primed || group_done;
        o_last_rep  = report ? value : i_last_rep;
        o_last_time = report ? i_now_ms : i_last_time;
        o_result.report = report;
        o_result.value  = value;
    end

endmodule

@@ hw/rtl/oversampled_ema_report_filter_unit.sv @@
// Top level of the oversampled EMA report filter: pipeline control, registers, output.
//
// Input channel: i_in_valid with o_in_stall carries one converter sample with its
// channel and millisecond time per transaction. Samples of a channel at or above
// CHANNELS are taken and dropped. Every OVERSAMPLE samples of one channel form a
// mean that drives a quarter-weight EMA; a report transaction (channel, rounded
// level) leaves on o_out_valid with i_out_stall when the level moved by the
// threshold, the heartbeat time ran out, or the channel was just primed.
// Configuration: i_cfg_valid with o_cfg_ready (always high) writes register 0
// (threshold, values outside 1..500 ignored) or register 1 (heartbeat in ms).
// Throughput is one sample per cycle unless a reporting sample waits on a stalled
// output. The state of all channels sits in one memory with a registered read: a
// sample reads its channel on acceptance and is updated and written back when the
// update stage advances, where a report is also registered into o_out_valid.
// Back-to-back samples of one channel are served by forwarding the write.
// Reset clears the pipeline, output register, registers and the memory valid
// bits at once; no clearing pass is needed. While the receiver stalls, a full
// output register holds its report; only a sample that would report then
// holds the update stage, and the input stalls behind it.
module oversampled_ema_report_filter_unit #(
    parameter int CHANNELS   = emarf_pkg::CHANNELS_DEF,
    parameter int OVERSAMPLE = emarf_pkg::OVERSAMPLE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [emarf_pkg::CHAN_W-1:0]     i_channel,
    input  logic [emarf_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [emarf_pkg::TIME_W-1:0]     i_now_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [emarf_pkg::CHAN_W-1:0]     o_report_channel,
    output logic [emarf_pkg::SAMPLE_W-1:0]   o_report_value,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [emarf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [emarf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int OS_W   = $clog2(OVERSAMPLE);
    localparam int SUM_W  = emarf_pkg::SAMPLE_W + OS_W;
    localparam int CNT_W  = (OS_W > 0) ? OS_W : 1;
    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LVL_W  = emarf_pkg::LEVEL_W;
    localparam int SMP_W  = emarf_pkg::SAMPLE_W;
    localparam int TIM_W  = emarf_pkg::TIME_W;
    localparam int WORD_W = SUM_W + CNT_W + LVL_W + 1 + SMP_W + TIM_W;

    // Configuration registers.
    logic [emarf_pkg::THR_W-1:0] r_threshold;
    logic [emarf_pkg::HB_W-1:0]  r_heartbeat;
    logic [emarf_pkg::THR_W-1:0] cfg_thr;

    // Update stage.
    logic                    r_s1_valid;
    logic [emarf_pkg::CHAN_W-1:0] r_s1_channel;
    logic [SMP_W-1:0]        r_s1_sample;
    logic [TIM_W-1:0]        r_s1_now;

    // Output register.
    logic                    r_o_valid;
    logic [emarf_pkg::CHAN_W-1:0] r_o_channel;
    logic [SMP_W-1:0]        r_o_value;

    logic in_accept;
    logic in_range;
    logic out_free;
    logic s1_go;

    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] wr_word;

    logic [SUM_W-1:0]  st_sum,      nx_sum;
    logic [CNT_W-1:0]  st_cnt,      nx_cnt;
    logic [LVL_W-1:0]  st_level,    nx_level;
    logic              st_primed,   nx_primed;
    logic [SMP_W-1:0]  st_last_rep, nx_last_rep;
    logic [TIM_W-1:0]  st_last_time, nx_last_time;
    emarf_pkg::t_result s1_res;

    // Handshake control: the update stage only waits for a report it cannot place.
    assign out_free   = !r_o_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && (out_free || !s1_res.report);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_range   = (int'(i_channel) < CHANNELS);
    assign o_cfg_ready = 1'b1;

    // State memory: read on acceptance, write back when the update stage advances.
    emarf_state_ram #(
        .DEPTH  (CHANNELS),
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept && in_range),
        .i_rd_addr (ADDR_W'(i_channel)),
        .i_wr_en   (s1_go),
        .i_wr_addr (ADDR_W'(r_s1_channel)),
        .i_wr_data (wr_word),
        .o_rd_data (rd_word)
    );

    assign {st_sum, st_cnt, st_level, st_primed, st_last_rep, st_last_time} = rd_word;
    assign wr_word = {nx_sum, nx_cnt, nx_level, nx_primed, nx_last_rep, nx_last_time};

    // Read-modify-write datapath.
    emarf_update #(
        .OVERSAMPLE (OVERSAMPLE),
        .SUM_W      (SUM_W),
        .CNT_W      (CNT_W)
    ) u_update (
        .i_sum       (st_sum),
        .i_cnt       (st_cnt),
        .i_level     (st_level),
        .i_primed    (st_primed),
        .i_last_rep  (st_last_rep),
        .i_last_time (st_last_time),
        .i_sample    (r_s1_sample),
        .i_now_ms    (r_s1_now),
        .i_threshold (r_threshold),
        .i_heartbeat (r_heartbeat),
        .o_sum       (nx_sum),
        .o_cnt       (nx_cnt),
        .o_level     (nx_level),
        .o_primed    (nx_primed),
        .o_last_rep  (nx_last_rep),
        .o_last_time (nx_last_time),
        .o_result    (s1_res)
    );

    // Configuration writes; a threshold outside its legal range is ignored.
    assign cfg_thr = i_cfg_data[emarf_pkg::THR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= emarf_pkg::THR_RESET;
            r_heartbeat <= emarf_pkg::HB_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                emarf_pkg::REG_THRESHOLD: begin
                    if ((cfg_thr >= emarf_pkg::THR_MIN) && (cfg_thr <= emarf_pkg::THR_MAX)) begin
                        r_threshold <= cfg_thr;
                    end
                end
                emarf_pkg::REG_HEARTBEAT: begin
                    r_heartbeat <= i_cfg_data[emarf_pkg::HB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Update stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= in_range;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Update stage payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_channel <= i_channel;
            r_s1_sample  <= i_sample;
            r_s1_now     <= i_now_ms;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_go && s1_res.report) begin
            r_o_valid <= 1'b1;
        end else if (out_free) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (s1_go && s1_res.report) begin
            r_o_channel <= r_s1_channel;
            r_o_value   <= s1_res.value;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_report_channel = r_o_channel;
    assign o_report_value   = r_o_value;

    // The input only stalls behind an occupied update stage.
    a_stall_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with an empty update stage");

    // A report leaving the update stage appears in the output register next cycle.
    a_report_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_res.report) |=>
            (o_out_valid && (o_report_channel == $past(r_s1_channel))))
        else $error("report lost between update stage and output register");

    // The threshold register never leaves its legal range.
    a_threshold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_threshold >= emarf_pkg::THR_MIN) && (r_threshold <= emarf_pkg::THR_MAX))
        else $error("threshold register out of range");

    // A report held under stall must not be overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_out_stall) |-> !(s1_go && s1_res.report))
        else $error("pending report overwritten");

endmodule
